// ===== design/sbx_pkg.sv =====
// sbx_pkg: shared constants, opcode codes, decode and local index functions and the
// controller/datapath command and status types of the bytecode execute unit.
// No dependencies.
package sbx_pkg;

    // storage sizes
    localparam int STACK_DEPTH = 64;
    localparam int LOCAL_COUNT = 256;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SP_AW       = $clog2(STACK_DEPTH);
    localparam int LOC_AW      = $clog2(LOCAL_COUNT);

    // payload widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 64;

    // opcodes
    localparam logic [7:0] OP_ACONST_NULL   = 8'h01;
    localparam logic [7:0] OP_ICONST_M1     = 8'h02;
    localparam logic [7:0] OP_ICONST_0      = 8'h03;
    localparam logic [7:0] OP_ICONST_1      = 8'h04;
    localparam logic [7:0] OP_ICONST_2      = 8'h05;
    localparam logic [7:0] OP_ICONST_3      = 8'h06;
    localparam logic [7:0] OP_ICONST_4      = 8'h07;
    localparam logic [7:0] OP_ICONST_5      = 8'h08;
    localparam logic [7:0] OP_BIPUSH        = 8'h10;
    localparam logic [7:0] OP_SIPUSH        = 8'h11;
    localparam logic [7:0] OP_LDC           = 8'h12;
    localparam logic [7:0] OP_ILOAD         = 8'h15;
    localparam logic [7:0] OP_ILOAD_0       = 8'h1A;
    localparam logic [7:0] OP_ILOAD_1       = 8'h1B;
    localparam logic [7:0] OP_ILOAD_2       = 8'h1C;
    localparam logic [7:0] OP_ILOAD_3       = 8'h1D;
    localparam logic [7:0] OP_ISTORE        = 8'h36;
    localparam logic [7:0] OP_ISTORE_0      = 8'h3B;
    localparam logic [7:0] OP_ISTORE_1      = 8'h3C;
    localparam logic [7:0] OP_ISTORE_2      = 8'h3D;
    localparam logic [7:0] OP_ISTORE_3      = 8'h3E;
    localparam logic [7:0] OP_POP           = 8'h57;
    localparam logic [7:0] OP_DUP           = 8'h59;
    localparam logic [7:0] OP_IADD          = 8'h60;
    localparam logic [7:0] OP_ISUB          = 8'h64;
    localparam logic [7:0] OP_IMUL          = 8'h68;
    localparam logic [7:0] OP_IDIV          = 8'h6C;
    localparam logic [7:0] OP_IREM          = 8'h70;
    localparam logic [7:0] OP_INEG          = 8'h74;
    localparam logic [7:0] OP_ISHL          = 8'h78;
    localparam logic [7:0] OP_ISHR          = 8'h7A;
    localparam logic [7:0] OP_IAND          = 8'h7E;
    localparam logic [7:0] OP_IOR           = 8'h80;
    localparam logic [7:0] OP_IXOR          = 8'h82;
    localparam logic [7:0] OP_IINC          = 8'h84;
    localparam logic [7:0] OP_IFEQ          = 8'h99;
    localparam logic [7:0] OP_IFNE          = 8'h9A;
    localparam logic [7:0] OP_IFLT          = 8'h9B;
    localparam logic [7:0] OP_IFGE          = 8'h9C;
    localparam logic [7:0] OP_IFGT          = 8'h9D;
    localparam logic [7:0] OP_IFLE          = 8'h9E;
    localparam logic [7:0] OP_IF_ICMPEQ     = 8'h9F;
    localparam logic [7:0] OP_IF_ICMPNE     = 8'hA0;
    localparam logic [7:0] OP_IF_ICMPLT     = 8'hA1;
    localparam logic [7:0] OP_IF_ICMPGE     = 8'hA2;
    localparam logic [7:0] OP_IF_ICMPGT     = 8'hA3;
    localparam logic [7:0] OP_IF_ICMPLE     = 8'hA4;
    localparam logic [7:0] OP_GOTO          = 8'hA7;
    localparam logic [7:0] OP_IRETURN       = 8'hAC;
    localparam logic [7:0] OP_RETURN        = 8'hB1;
    localparam logic [7:0] OP_GETSTATIC     = 8'hB2;
    localparam logic [7:0] OP_PUTSTATIC     = 8'hB3;
    localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hB6;
    localparam logic [7:0] OP_INVOKESPECIAL = 8'hB7;
    localparam logic [7:0] OP_INVOKESTATIC  = 8'hB8;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_UNF = 2'd2;

    // static properties of an opcode
    typedef struct packed {
        logic [1:0] len;
        logic [1:0] need;
        logic [1:0] grow;
        logic       halt;
    } sbx_dec_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
        logic div_start;
        logic commit;
        logic top_ld;
        logic out_ld;
    } sbx_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_div;
        logic ok;
        logic refetch;
        logic div_done;
        logic out_free;
    } sbx_sts_t;

    function automatic sbx_dec_t sbx_decode(input logic [7:0] op);
        sbx_dec_t d;
        d = '{len: 2'd1, need: 2'd0, grow: 2'd0, halt: 1'b0};
        case (op) inside
            OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_2,
            OP_ICONST_3, OP_ICONST_4, OP_ICONST_5, OP_ILOAD_0, OP_ILOAD_1,
            OP_ILOAD_2, OP_ILOAD_3: begin
                d.grow = 2'd1;
            end
            OP_BIPUSH, OP_LDC, OP_ILOAD: begin
                d.len = 2'd2; d.grow = 2'd1;
            end
            OP_SIPUSH, OP_GETSTATIC: begin
                d.len = 2'd3; d.grow = 2'd1;
            end
            OP_ISTORE: begin
                d.len = 2'd2; d.need = 2'd1;
            end
            OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3, OP_POP: begin
                d.need = 2'd1;
            end
            OP_DUP: begin
                d.need = 2'd1; d.grow = 2'd2;
            end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR,
            OP_IAND, OP_IOR, OP_IXOR: begin
                d.need = 2'd2; d.grow = 2'd1;
            end
            OP_INEG: begin
                d.need = 2'd1; d.grow = 2'd1;
            end
            OP_IINC, OP_GOTO, OP_INVOKEVIRTUAL, OP_INVOKESPECIAL,
            OP_INVOKESTATIC: begin
                d.len = 2'd3;
            end
            OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE,
            OP_PUTSTATIC: begin
                d.len = 2'd3; d.need = 2'd1;
            end
            OP_IF_ICMPEQ, OP_IF_ICMPNE, OP_IF_ICMPLT, OP_IF_ICMPGE,
            OP_IF_ICMPGT, OP_IF_ICMPLE: begin
                d.len = 2'd3; d.need = 2'd2;
            end
            OP_IRETURN, OP_RETURN: begin
                d.halt = 1'b1;
            end
            default: begin
                d.len = 2'd1;
            end
        endcase
        return d;
    endfunction

    // local variable index used by an opcode
    function automatic logic [7:0] sbx_loc_index(input logic [7:0] op,
                                                 input logic [7:0] bop);
        logic [7:0] idx;
        case (op) inside
            OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2, OP_ILOAD_3:     idx = op - OP_ILOAD_0;
            OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3: idx = op - OP_ISTORE_0;
            default:                                            idx = bop;
        endcase
        return idx;
    endfunction

endpackage

// ===== design/sbx_div.sv =====
// sbx_div: iterative signed 32-bit divider, one quotient bit per cycle.
// Gives quotient or remainder with Java rounding; divide by zero gives 0.
// Depends on sbx_pkg (none of its items needed beyond the import).
module sbx_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        rem,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] result
);
    import sbx_pkg::*;

    localparam int STEPS = 32;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  iter_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        zero_reg;
    logic        rem_reg;

    logic [32:0] r_shift;
    logic        fits;

    // one restoring step
    assign r_shift = {r_reg, q_reg[31]};
    assign fits    = r_shift >= {1'b0, d_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 5'd1;
                if (iter_reg == 5'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg     <= dividend[31] ? 32'd0 - dividend : dividend;
            d_reg     <= divisor[31] ? 32'd0 - divisor : divisor;
            r_reg     <= '0;
            neg_q_reg <= dividend[31] ^ divisor[31];
            neg_r_reg <= dividend[31];
            zero_reg  <= divisor == 32'd0;
            rem_reg   <= rem;
        end else if (busy_reg) begin
            r_reg <= fits ? 32'(r_shift - {1'b0, d_reg}) : r_shift[31:0];
            q_reg <= {q_reg[30:0], fits};
        end
    end

    // sign fix-up
    always_comb begin
        if (zero_reg)
            result = '0;
        else if (rem_reg)
            result = neg_r_reg ? 32'd0 - r_reg : r_reg;
        else
            result = neg_q_reg ? 32'd0 - q_reg : q_reg;
    end

    assign done = done_reg;

endmodule

// ===== design/sbx_dp.sv =====
// sbx_dp: datapath of the execute unit: instruction registers, operand stack
// memory with a cached top, local variables, ALU, divider and output register.
// Depends on sbx_pkg and sbx_div.
module sbx_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sbx_pkg::sbx_cmd_t    cmd,
    output sbx_pkg::sbx_sts_t    sts,
    input  logic [7:0]           mode,
    input  logic [15:0]          instr_addr,
    input  logic [7:0]           byte_operand,
    input  logic signed [15:0]   imm_word,
    input  logic signed [7:0]    inc_delta,
    input  logic signed [31:0]   const_value,
    input  logic                 const_valid,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          next_addr,
    output logic                 halted,
    output logic [1:0]           status,
    output logic signed [31:0]   top_value,
    output logic [6:0]           stack_depth
);
    import sbx_pkg::*;

    // instruction registers
    logic [7:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  bop_reg;
    logic [15:0] imm_reg;
    logic [7:0]  dlt_reg;
    logic [31:0] cval_reg;
    logic        cok_reg;

    // stack and locals
    logic [31:0] stk_mem [STACK_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0] tos_reg;
    logic [31:0] rd_reg;
    logic [31:0] loc_mem [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] loc_vld_reg;
    logic [31:0] loc_q_reg;
    logic        loc_v_reg;

    // execute results
    logic [31:0] res_reg;
    logic        taken_reg;
    logic [1:0]  status_reg;

    // output register
    logic        m_valid_reg;
    logic [15:0] next_addr_reg;
    logic        halted_reg;
    logic [1:0]  status_out_reg;
    logic [31:0] top_reg;
    logic [6:0]  depth_reg;

    sbx_dec_t         dec;
    logic [CNT_W:0]   cnt_x;
    logic [CNT_W:0]   need_x;
    logic [CNT_W:0]   grow_x;
    logic [1:0]       status_c;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] rd_ptr;
    logic [7:0]       lidx;
    logic             lidx_ok;
    logic [31:0]      loc_val;
    logic [31:0]      a_val;
    logic [31:0]      b_val;
    logic [31:0]      res_c;
    logic             taken_c;
    logic             is_div;
    logic             div_done;
    logic [31:0]      div_res;
    logic [31:0]      commit_res;
    logic             ok_reg_c;
    logic             loc_we;
    logic [31:0]      loc_wd;
    logic             push_spill;

    assign dec    = sbx_decode(op_reg);
    assign is_div = (op_reg == OP_IDIV) || (op_reg == OP_IREM);
    assign a_val  = rd_reg;
    assign b_val  = tos_reg;

    // underflow / overflow check against the current depth
    assign cnt_x  = {1'b0, cnt_reg};
    assign need_x = (CNT_W + 1)'(dec.need);
    assign grow_x = (CNT_W + 1)'(dec.grow);
    always_comb begin
        if (cnt_x < need_x)
            status_c = ST_UNF;
        else if (cnt_x - need_x + grow_x > (CNT_W + 1)'(STACK_DEPTH))
            status_c = ST_OVF;
        else
            status_c = ST_OK;
    end

    assign cnt_next = CNT_W'(cnt_x - need_x + grow_x);

    // instruction capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= mode;
            addr_reg <= instr_addr;
            bop_reg  <= byte_operand;
            imm_reg  <= imm_word;
            dlt_reg  <= inc_delta;
            cval_reg <= const_value;
            cok_reg  <= const_valid;
        end
    end

    // stack memory: read second entry, or the new top after a pop
    assign rd_ptr     = cmd.commit ? cnt_next - CNT_W'(1) : cnt_reg - CNT_W'(2);
    assign ok_reg_c   = status_reg == ST_OK;
    assign push_spill = ok_reg_c && (dec.grow > dec.need) && (cnt_reg != '0);
    always_ff @(posedge aclk) begin
        if (cmd.rd || cmd.commit)
            rd_reg <= stk_mem[rd_ptr[SP_AW-1:0]];
        if (cmd.commit && push_spill)
            stk_mem[SP_AW'(cnt_reg - CNT_W'(1))] <= tos_reg;
    end

    // local variable read
    assign lidx    = sbx_loc_index(op_reg, bop_reg);
    assign lidx_ok = {1'b0, lidx} < 9'(LOCAL_COUNT);
    assign loc_val = loc_v_reg ? loc_q_reg : 32'd0;
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            loc_q_reg <= loc_mem[lidx[LOC_AW-1:0]];
            loc_v_reg <= loc_vld_reg[lidx[LOC_AW-1:0]] && lidx_ok;
        end
    end

    // local variable write: istore and iinc
    always_comb begin
        loc_we = 1'b0;
        loc_wd = tos_reg;
        case (op_reg) inside
            OP_ISTORE, OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3: begin
                loc_we = 1'b1;
            end
            OP_IINC: begin
                loc_we = 1'b1;
                loc_wd = loc_val + {{24{dlt_reg[7]}}, dlt_reg};
            end
            default: begin
                loc_we = 1'b0;
            end
        endcase
        loc_we = loc_we && cmd.commit && ok_reg_c && lidx_ok;
    end

    always_ff @(posedge aclk) begin
        if (loc_we)
            loc_mem[lidx[LOC_AW-1:0]] <= loc_wd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            loc_vld_reg <= '0;
        else if (loc_we)
            loc_vld_reg[lidx[LOC_AW-1:0]] <= 1'b1;
    end

    // alu
    always_comb begin
        case (op_reg) inside
            OP_ICONST_M1: res_c = 32'hFFFF_FFFF;
            OP_ICONST_0, OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4,
            OP_ICONST_5:  res_c = {24'd0, op_reg - OP_ICONST_0};
            OP_BIPUSH:    res_c = {{24{bop_reg[7]}}, bop_reg};
            OP_SIPUSH:    res_c = {{16{imm_reg[15]}}, imm_reg};
            OP_LDC:       res_c = cok_reg ? cval_reg : 32'd0;
            OP_ILOAD, OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2,
            OP_ILOAD_3:   res_c = loc_val;
            OP_DUP:       res_c = b_val;
            OP_IADD:      res_c = a_val + b_val;
            OP_ISUB:      res_c = a_val - b_val;
            OP_IMUL:      res_c = a_val * b_val;
            OP_INEG:      res_c = 32'd0 - b_val;
            OP_ISHL:      res_c = a_val << b_val[4:0];
            OP_ISHR:      res_c = $unsigned($signed(a_val) >>> b_val[4:0]);
            OP_IAND:      res_c = a_val & b_val;
            OP_IOR:       res_c = a_val | b_val;
            OP_IXOR:      res_c = a_val ^ b_val;
            default:      res_c = 32'd0;
        endcase
    end

    // branch condition
    always_comb begin
        case (op_reg)
            OP_IFEQ:      taken_c = b_val == 32'd0;
            OP_IFNE:      taken_c = b_val != 32'd0;
            OP_IFLT:      taken_c = $signed(b_val) < 0;
            OP_IFGE:      taken_c = $signed(b_val) >= 0;
            OP_IFGT:      taken_c = $signed(b_val) > 0;
            OP_IFLE:      taken_c = $signed(b_val) <= 0;
            OP_IF_ICMPEQ: taken_c = a_val == b_val;
            OP_IF_ICMPNE: taken_c = a_val != b_val;
            OP_IF_ICMPLT: taken_c = $signed(a_val) < $signed(b_val);
            OP_IF_ICMPGE: taken_c = $signed(a_val) >= $signed(b_val);
            OP_IF_ICMPGT: taken_c = $signed(a_val) > $signed(b_val);
            OP_IF_ICMPLE: taken_c = $signed(a_val) <= $signed(b_val);
            OP_GOTO:      taken_c = 1'b1;
            default:      taken_c = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_reg    <= res_c;
            taken_reg  <= taken_c && (status_c == ST_OK);
            status_reg <= status_c;
        end
    end

    sbx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .rem      (op_reg == OP_IREM),
        .dividend (a_val),
        .divisor  (b_val),
        .done     (div_done),
        .result   (div_res)
    );

    assign commit_res = is_div ? div_res : res_reg;

    // stack pointer and cached top
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.commit && ok_reg_c) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && ok_reg_c && dec.grow != 2'd0)
            tos_reg <= commit_res;
        else if (cmd.top_ld)
            tos_reg <= rd_reg;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            next_addr_reg  <= taken_reg ? addr_reg + imm_reg
                                        : addr_reg + {14'd0, dec.len};
            halted_reg     <= dec.halt;
            status_out_reg <= status_reg;
            top_reg        <= (cnt_reg != '0) ? tos_reg : 32'd0;
            depth_reg      <= 7'(cnt_reg);
        end
    end

    // status to the controller
    assign sts.is_div   = is_div;
    assign sts.ok       = status_c == ST_OK;
    assign sts.refetch  = ok_reg_c && dec.grow == 2'd0 && dec.need != 2'd0;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign next_addr   = next_addr_reg;
    assign halted      = halted_reg;
    assign status      = status_out_reg;
    assign top_value   = top_reg;
    assign stack_depth = depth_reg;

endmodule

// ===== design/sbx_ctrl.sv =====
// sbx_ctrl: sequencing state machine of the execute unit.
// Issues commands to the datapath and reacts to its status.
// Depends on sbx_pkg.
module sbx_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbx_pkg::sbx_sts_t sts,
    output sbx_pkg::sbx_cmd_t cmd
);
    import sbx_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_DIVW   = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_TOPRD  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.is_div && sts.ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_DIVW: begin
                if (sts.div_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = sts.refetch ? S_TOPRD : S_DONE;
            end
            S_TOPRD: begin
                cmd.top_ld = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_ready = state_reg == S_IDLE;

endmodule

// ===== design/stack_bytecode_execute_unit.sv =====
// stack_bytecode_execute_unit: top level of the integer bytecode execute unit.
// Unpacks the input stream, joins sbx_ctrl and sbx_dp, packs the result stream.
// Depends on sbx_pkg, sbx_ctrl, sbx_dp.
//
// Usage:
//   One decoded instruction enters per transfer on the s_ channel; each one
//   produces exactly one result transfer on the m_ channel.
//   The unit keeps the operand stack (simple dual-port memory with a cached top
//   entry), the stack depth and the local variables between instructions.
//   Timing: an instruction is accepted only when the unit is idle. Its result
//   is valid after the read, execute, commit and done states; an instruction
//   that pops without pushing also passes a top-read state (the new top comes
//   back from the stack memory), and idiv/irem wait in a divide state (the
//   divider produces one quotient bit per cycle). The next instruction is
//   taken only once this result is in the output register.
//   Reset clears the stack depth, all local variables (per-entry valid bits)
//   and the result valid flag; the stack memory itself is not cleared.
//   If the receiver stalls, the finished result holds in the output register
//   and the next instruction is still taken and worked up to its write-back;
//   it then waits until the held result is taken.
module stack_bytecode_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[7:0], instr_addr[23:8], byte_operand[31:24], imm_word[47:32],
    // inc_delta[55:48], const_value[87:56], const_valid[88], zero fill
    input  logic [sbx_pkg::S_DATA_W-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_addr[15:0], halted[16], status[18:17], top_value[50:19],
    // stack_depth[57:51], zero fill
    output logic [sbx_pkg::M_DATA_W-1:0] m_tdata
);
    import sbx_pkg::*;

    sbx_cmd_t           cmd;
    sbx_sts_t           sts;
    logic [15:0]        next_addr;
    logic               halted;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;

    sbx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbx_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (s_tdata[7:0]),
        .instr_addr   (s_tdata[23:8]),
        .byte_operand (s_tdata[31:24]),
        .imm_word     (s_tdata[47:32]),
        .inc_delta    (s_tdata[55:48]),
        .const_value  (s_tdata[87:56]),
        .const_valid  (s_tdata[88]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .next_addr    (next_addr),
        .halted       (halted),
        .status       (status),
        .top_value    (top_value),
        .stack_depth  (stack_depth)
    );

    // result packing
    assign m_tdata = {6'd0, stack_depth, top_value, status, halted, next_addr};

endmodule

// ===== design/sbx_chk.sv =====
// sbx_chk: port-level checker for stack_bytecode_execute_unit, with its bind.
// Depends on sbx_pkg for the payload widths and the stack size.
module sbx_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [sbx_pkg::S_DATA_W-1:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [sbx_pkg::M_DATA_W-1:0] m_tdata
);
    import sbx_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one instruction at a time
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    // status code is always a defined one
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:17] != 2'd3)
        else $error("undefined status code");

    // depth never exceeds the stack size
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[57:51] <= 7'(STACK_DEPTH))
        else $error("stack depth out of range");

endmodule

bind stack_bytecode_execute_unit sbx_chk u_sbx_chk (.*);

// ===== sim/tb_stack_bytecode_execute_unit.sv =====
// tb_stack_bytecode_execute_unit: self-checking testbench of the bytecode execute unit.
// Directed table then random opcode programs, checked against a behavioral predictor.
// Depends on sbx_pkg and stack_bytecode_execute_unit.
`timescale 1ns / 1ps

module tb_stack_bytecode_execute_unit;
    import sbx_pkg::*;

    typedef struct packed {
        logic [7:0]  mode;
        logic [15:0] instr_addr;
        logic [7:0]  byte_operand;
        logic [15:0] imm_word;
        logic [7:0]  inc_delta;
        logic [31:0] const_value;
        logic        const_valid;
    } instr_t;

    typedef struct packed {
        logic [15:0] next_addr;
        logic        halted;
        logic [1:0]  status;
        logic [31:0] top_value;
        logic [6:0]  stack_depth;
    } exec_res_t;

    typedef struct {
        instr_t    ins;
        logic      fixed;
        exec_res_t res;
    } dir_row_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1150;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state
    logic [31:0] pred_stack [STACK_DEPTH];
    int          pred_count;
    logic [31:0] pred_locals [LOCAL_COUNT];

    exec_res_t   result_queue [$];
    int          mismatch_count;
    int          idle_cycles;
    int          rx_wait;
    logic        send_done;
    logic        timed_out;

    stack_bytecode_execute_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic logic [S_DATA_W-1:0] pack_instr(input instr_t t);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[7:0]   = t.mode;
        d[23:8]  = t.instr_addr;
        d[31:24] = t.byte_operand;
        d[47:32] = t.imm_word;
        d[55:48] = t.inc_delta;
        d[87:56] = t.const_value;
        d[88]    = t.const_valid;
        return d;
    endfunction

    function automatic logic [31:0] sdiv_java(input logic [31:0] a, input logic [31:0] b,
                                              input logic rem);
        logic [31:0] ua, ub, r;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        if (b == 0) return 32'd0;
        if (rem) begin
            r = ua % ub;
            return a[31] ? -r : r;
        end
        r = ua / ub;
        return (a[31] != b[31]) ? -r : r;
    endfunction

    // execute one instruction on the predictor state
    function automatic exec_res_t execute_instr(input instr_t t);
        exec_res_t o;
        int len, need, grow;
        logic [31:0] a, b, r, imm, loc;
        logic taken;
        len = 1; need = 0; grow = 0; a = 0; b = 0; r = 0; taken = 0;
        imm = {{16{t.imm_word[15]}}, t.imm_word};
        o = '0;
        case (t.mode)
            OP_ACONST_NULL, OP_ICONST_M1, OP_ICONST_0, OP_ICONST_1, OP_ICONST_2,
            OP_ICONST_3, OP_ICONST_4, OP_ICONST_5, OP_ILOAD_0, OP_ILOAD_1,
            OP_ILOAD_2, OP_ILOAD_3: grow = 1;
            OP_BIPUSH, OP_LDC, OP_ILOAD: begin len = 2; grow = 1; end
            OP_SIPUSH, OP_GETSTATIC: begin len = 3; grow = 1; end
            OP_ISTORE: begin len = 2; need = 1; end
            OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3, OP_POP: need = 1;
            OP_DUP: begin need = 1; grow = 2; end
            OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR,
            OP_IAND, OP_IOR, OP_IXOR: begin need = 2; grow = 1; end
            OP_INEG: begin need = 1; grow = 1; end
            OP_IINC, OP_GOTO, OP_INVOKEVIRTUAL, OP_INVOKESPECIAL,
            OP_INVOKESTATIC: len = 3;
            OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE,
            OP_PUTSTATIC: begin len = 3; need = 1; end
            OP_IF_ICMPEQ, OP_IF_ICMPNE, OP_IF_ICMPLT, OP_IF_ICMPGE,
            OP_IF_ICMPGT, OP_IF_ICMPLE: begin len = 3; need = 2; end
            OP_IRETURN, OP_RETURN: o.halted = 1'b1;
            default: ;
        endcase
        if (pred_count < need) o.status = ST_UNF;
        else if (pred_count - need + grow > STACK_DEPTH) o.status = ST_OVF;
        else o.status = ST_OK;

        if (o.status == ST_OK) begin
            if (need >= 1) b = pred_stack[pred_count-1];
            if (need >= 2) a = pred_stack[pred_count-2];
            pred_count -= need;
            case (t.mode)
                OP_ICONST_M1: r = 32'hFFFF_FFFF;
                OP_ICONST_0, OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4,
                OP_ICONST_5: r = t.mode - OP_ICONST_0;
                OP_BIPUSH: r = {{24{t.byte_operand[7]}}, t.byte_operand};
                OP_SIPUSH: r = imm;
                OP_LDC: r = t.const_valid ? t.const_value : 32'd0;
                OP_ILOAD: r = pred_locals[t.byte_operand];
                OP_ILOAD_0, OP_ILOAD_1, OP_ILOAD_2, OP_ILOAD_3:
                    r = pred_locals[t.mode - OP_ILOAD_0];
                OP_ISTORE: pred_locals[t.byte_operand] = b;
                OP_ISTORE_0, OP_ISTORE_1, OP_ISTORE_2, OP_ISTORE_3:
                    pred_locals[t.mode - OP_ISTORE_0] = b;
                OP_DUP: begin pred_stack[pred_count] = b; pred_count++; r = b; end
                OP_IADD: r = a + b;
                OP_ISUB: r = a - b;
                OP_IMUL: r = a * b;
                OP_IDIV: r = sdiv_java(a, b, 1'b0);
                OP_IREM: r = sdiv_java(a, b, 1'b1);
                OP_INEG: r = -b;
                OP_ISHL: r = a << b[4:0];
                OP_ISHR: r = $signed(a) >>> b[4:0];
                OP_IAND: r = a & b;
                OP_IOR:  r = a | b;
                OP_IXOR: r = a ^ b;
                OP_IINC: begin
                    loc = pred_locals[t.byte_operand];
                    pred_locals[t.byte_operand] = loc + {{24{t.inc_delta[7]}}, t.inc_delta};
                end
                OP_IFEQ: taken = (b == 0);
                OP_IFNE: taken = (b != 0);
                OP_IFLT: taken = $signed(b) < 0;
                OP_IFGE: taken = $signed(b) >= 0;
                OP_IFGT: taken = $signed(b) > 0;
                OP_IFLE: taken = $signed(b) <= 0;
                OP_IF_ICMPEQ: taken = (a == b);
                OP_IF_ICMPNE: taken = (a != b);
                OP_IF_ICMPLT: taken = $signed(a) < $signed(b);
                OP_IF_ICMPGE: taken = $signed(a) >= $signed(b);
                OP_IF_ICMPGT: taken = $signed(a) > $signed(b);
                OP_IF_ICMPLE: taken = $signed(a) <= $signed(b);
                OP_GOTO: taken = 1'b1;
                default: ;
            endcase
            if (grow == 1 || t.mode == OP_DUP) begin
                pred_stack[pred_count] = r;
                pred_count++;
            end
        end
        o.next_addr   = taken ? t.instr_addr + imm[15:0] : t.instr_addr + 16'(len);
        o.top_value   = pred_count != 0 ? pred_stack[pred_count-1] : 32'd0;
        o.stack_depth = 7'(pred_count);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    function automatic instr_t mk(input logic [7:0] op, input logic [7:0] bop,
                                  input logic [15:0] imm, input logic [7:0] dlt,
                                  input logic [31:0] cv, input logic cok);
        instr_t t;
        t.mode = op; t.instr_addr = 16'($urandom); t.byte_operand = bop;
        t.imm_word = imm; t.inc_delta = dlt; t.const_value = cv; t.const_valid = cok;
        return t;
    endfunction

    // random opcode weighted toward a well-formed stream
    function automatic logic [7:0] pick_opcode();
        logic [7:0] ops [] = '{OP_ICONST_M1, OP_ICONST_0, OP_ICONST_5, OP_BIPUSH, OP_SIPUSH,
            OP_LDC, OP_ILOAD, OP_ILOAD_0, OP_ILOAD_3, OP_ISTORE, OP_ISTORE_0,
            OP_ISTORE_2, OP_POP, OP_DUP, OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV,
            OP_IREM, OP_INEG, OP_ISHL, OP_ISHR, OP_IAND, OP_IOR, OP_IXOR, OP_IINC,
            OP_IFEQ, OP_IFNE, OP_IFLT, OP_IFGE, OP_IFGT, OP_IFLE, OP_IF_ICMPEQ,
            OP_IF_ICMPNE, OP_IF_ICMPLT, OP_IF_ICMPGE, OP_IF_ICMPGT, OP_IF_ICMPLE,
            OP_GOTO, OP_IRETURN, OP_RETURN, OP_GETSTATIC, OP_PUTSTATIC,
            OP_INVOKEVIRTUAL, OP_INVOKESPECIAL, OP_INVOKESTATIC, OP_ACONST_NULL,
            OP_ICONST_1, OP_ICONST_2, OP_ICONST_3, OP_ICONST_4, OP_ILOAD_1,
            OP_ILOAD_2, OP_ISTORE_1, OP_ISTORE_3};
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 8'($urandom);
        // divides get extra picks on top of their place in the list, though they are slow
        if (sel < 11) return ($urandom_range(0, 1) != 0) ? OP_IDIV : OP_IREM;
        return ops[$urandom_range(0, ops.size() - 1)];
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    // valid stays up between back-to-back items, drops only for a gap
    task automatic send_instr(input instr_t t, input logic fixed, input exec_res_t want);
        exec_res_t p;
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= pack_instr(t);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = execute_instr(t);
        result_queue.push_back(fixed ? want : p);
    endtask

    // stimulus
    initial begin
        dir_row_t dir [$];
        dir_row_t row;
        instr_t t;
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        send_done = 1'b0;
        mismatch_count = 0;
        pred_count = 0;
        for (int i = 0; i < LOCAL_COUNT; i++) pred_locals[i] = 32'd0;
        for (int i = 0; i < STACK_DEPTH; i++) pred_stack[i] = 32'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: fixed expectations where obvious
        row.fixed = 1'b1;
        row.ins = mk(OP_POP, 0, 0, 0, 0, 0); row.ins.instr_addr = 16'h0010;
        row.res = '{16'h0011, 1'b0, ST_UNF, 32'd0, 7'd0}; dir.push_back(row);
        row.ins = mk(OP_IADD, 0, 0, 0, 0, 0); row.ins.instr_addr = 16'hFFFF;
        row.res = '{16'h0000, 1'b0, ST_UNF, 32'd0, 7'd0}; dir.push_back(row);
        row.ins = mk(OP_BIPUSH, 8'h80, 0, 0, 0, 0); row.ins.instr_addr = 16'h0100;
        row.res = '{16'h0102, 1'b0, ST_OK, 32'hFFFF_FF80, 7'd1}; dir.push_back(row);
        row.ins = mk(OP_SIPUSH, 0, 16'h7FFF, 0, 0, 0); row.ins.instr_addr = 16'hFFFE;
        row.res = '{16'h0001, 1'b0, ST_OK, 32'h0000_7FFF, 7'd2}; dir.push_back(row);
        row.ins = mk(OP_IRETURN, 0, 0, 0, 0, 0); row.ins.instr_addr = 16'h0200;
        row.res = '{16'h0201, 1'b1, ST_OK, 32'h0000_7FFF, 7'd2}; dir.push_back(row);
        row.ins = mk(OP_LDC, 0, 0, 0, 32'h8000_0000, 1); row.ins.instr_addr = 16'h0300;
        row.res = '{16'h0302, 1'b0, ST_OK, 32'h8000_0000, 7'd3}; dir.push_back(row);
        row.fixed = 1'b0;
        // idiv min / -1, then invalid ldc, div by zero, a shift, irem
        row.ins = mk(OP_ICONST_M1, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_IDIV, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_LDC, 0, 0, 0, 32'h7FFF_FFFF, 0); dir.push_back(row);
        row.ins = mk(OP_IDIV, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_BIPUSH, 8'h7F, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_ISHR, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_SIPUSH, 0, 16'h8000, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_IREM, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_ISTORE, 8'hFF, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_IINC, 8'hFF, 0, 8'h80, 0, 0); dir.push_back(row);
        row.ins = mk(OP_IINC, 8'h00, 0, 8'h7F, 0, 0); dir.push_back(row);
        row.ins = mk(OP_ILOAD, 8'hFF, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_ILOAD_0, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_IF_ICMPLT, 0, 16'h8000, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_GOTO, 0, 16'hFFFD, 0, 0, 0); dir.push_back(row);
        row.ins = mk(OP_INVOKESTATIC, 0, 0, 0, 0, 0); dir.push_back(row);
        row.ins = mk(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1); dir.push_back(row);
        row.ins = mk(OP_RETURN, 0, 0, 0, 0, 0); dir.push_back(row);
        foreach (dir[i]) send_instr(dir[i].ins, dir[i].fixed, dir[i].res);

        // random programs; occasional long push runs can reach overflow
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(40, 70)) begin
                    t = mk(OP_ICONST_5, 0, 0, 0, 0, 0);
                    send_instr(t, 1'b0, '0);
                    n++;
                end
            end
            t = mk(pick_opcode(), 8'($urandom), 16'($urandom), 8'($urandom),
                   pick_word(), 1'($urandom));
            if ($urandom_range(0, 3) != 0) t.byte_operand = 8'($urandom_range(0, 7));
            send_instr(t, 1'b0, '0);
            n++;
        end
        s_tvalid <= 1'b0;
        send_done = 1'b1;
    end

    // receiver: drops ready for a randomly drawn wait after each transfer
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= $urandom_range(0, 5);
        end else if (m_tvalid && m_tready) begin
            w = $urandom_range(0, 5);
            rx_wait  <= w;
            m_tready <= (w == 0);
        end else if (!m_tready) begin
            if (rx_wait <= 1) m_tready <= 1'b1;
            if (rx_wait > 0) rx_wait <= rx_wait - 1;
        end
    end

    // checker
    always @(posedge aclk) begin
        exec_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[57:0];
            got.next_addr   = m_tdata[15:0];
            got.halted      = m_tdata[16];
            got.status      = m_tdata[18:17];
            got.top_value   = m_tdata[50:19];
            got.stack_depth = m_tdata[57:51];
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = result_queue.pop_front();
                if (got.next_addr != want.next_addr)
                    report_mismatch("next_addr", got.next_addr, want.next_addr);
                if (got.halted != want.halted)
                    report_mismatch("halted", got.halted, want.halted);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.top_value != want.top_value)
                    report_mismatch("top_value", got.top_value, want.top_value);
                if (got.stack_depth != want.stack_depth)
                    report_mismatch("stack_depth", got.stack_depth, want.stack_depth);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        timed_out = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
            if (send_done && result_queue.size() == 0) break;
        end
        if (!timed_out) repeat (60) @(posedge aclk);
        if (!timed_out && mismatch_count == 0 && result_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/sbx_pkg.sv
design/sbx_div.sv
design/sbx_dp.sv
design/sbx_ctrl.sv
design/stack_bytecode_execute_unit.sv
design/sbx_chk.sv
sim/tb_stack_bytecode_execute_unit.sv
